>>> src/brse_pkg.sv
// Shared types, mode codes and the word popcount for the rank/select engine.
// Used by brse_store, brse_core and bitvector_rank_select_engine_unit.
package brse_pkg;

  // Item modes
  localparam logic [2:0] MODE_WRITE  = 3'd0;
  localparam logic [2:0] MODE_BUILD  = 3'd1;
  localparam logic [2:0] MODE_RANK   = 3'd2;
  localparam logic [2:0] MODE_SELECT = 3'd3;
  localparam logic [2:0] MODE_PREV   = 3'd4;
  localparam logic [2:0] MODE_TEST   = 3'd5;

  localparam logic [16:0] LEN_RESET = 17'd131071;

  typedef struct packed {
    logic [2:0]  mode;
    logic [11:0] word_index;
    logic [31:0] word_data;
    logic [16:0] position;
    logic [17:0] target_count;
  } brse_in_t;

  typedef struct packed {
    logic [17:0] answer;
    logic        bit_value;
    logic        not_found;
  } brse_out_t;

  // Write strobes toward the index store
  typedef struct packed {
    logic word;
    logic lcnt;
    logic blk;
    logic sb;
  } brse_we_t;

  // Ones in a 32-bit word, summed per nibble then across nibbles
  function automatic logic [5:0] popcnt32(input logic [31:0] v);
    logic [2:0] nib [8];
    logic [5:0] sum;
    for (int n = 0; n < 8; n++) begin
      nib[n] = 3'(v[4*n]) + 3'(v[4*n+1]) + 3'(v[4*n+2]) + 3'(v[4*n+3]);
    end
    sum = ((6'(nib[0]) + 6'(nib[1])) + (6'(nib[2]) + 6'(nib[3])))
        + ((6'(nib[4]) + 6'(nib[5])) + (6'(nib[6]) + 6'(nib[7])));
    return sum;
  endfunction

endpackage

>>> src/brse_store.sv
// Memories of the rank/select engine: bit words, local counts, block totals
// and superblock totals. Depends on brse_pkg for the write strobe struct.
module brse_store #(
  parameter int WORDS    = 4096,
  parameter int SB_WORDS = 16,
  localparam int WAW     = $clog2(WORDS),
  localparam int BAW     = (WORDS / 8 > 1) ? $clog2(WORDS / 8) : 1,
  localparam int SAW     = $clog2(WORDS / SB_WORDS + 1)
) (
  input  logic              clk_i,
  input  brse_pkg::brse_we_t we_i,
  input  logic [WAW-1:0]    word_waddr_i,
  input  logic [31:0]       word_wdata_i,
  input  logic [WAW-1:0]    word_raddr_i,
  output logic [31:0]       word_rdata_o,
  input  logic [WAW-1:0]    lcnt_waddr_i,
  input  logic [7:0]        lcnt_wdata_i,
  input  logic [WAW-1:0]    lcnt_raddr_i,
  output logic [7:0]        lcnt_rdata_o,
  input  logic [BAW-1:0]    blk_waddr_i,
  input  logic [17:0]       blk_wdata_i,
  input  logic [BAW-1:0]    blk_raddr_i,
  output logic [17:0]       blk_rdata_o,
  input  logic [SAW-1:0]    sb_waddr_i,
  input  logic [17:0]       sb_wdata_i,
  input  logic [SAW-1:0]    sb_raddr_i,
  output logic [17:0]       sb_rdata_o
);

  logic [31:0] word_mem [WORDS];
  logic [7:0]  lcnt_mem [WORDS];
  logic [17:0] blk_mem  [WORDS / 8];
  logic [17:0] sb_mem   [WORDS / SB_WORDS + 1];

  // Bit words
  always_ff @(posedge clk_i) begin
    if (we_i.word) begin
      word_mem[word_waddr_i] <= word_wdata_i;
    end
    word_rdata_o <= word_mem[word_raddr_i];
  end

  // Ones before each word inside its block
  always_ff @(posedge clk_i) begin
    if (we_i.lcnt) begin
      lcnt_mem[lcnt_waddr_i] <= lcnt_wdata_i;
    end
    lcnt_rdata_o <= lcnt_mem[lcnt_raddr_i];
  end

  // Ones before each block
  always_ff @(posedge clk_i) begin
    if (we_i.blk) begin
      blk_mem[blk_waddr_i] <= blk_wdata_i;
    end
    blk_rdata_o <= blk_mem[blk_raddr_i];
  end

  // Cumulative superblock totals
  always_ff @(posedge clk_i) begin
    if (we_i.sb) begin
      sb_mem[sb_waddr_i] <= sb_wdata_i;
    end
    sb_rdata_o <= sb_mem[sb_raddr_i];
  end

endmodule

>>> src/brse_core.sv
// Sequencer and shared popcount/bit-scan datapath of the rank/select engine.
// Depends on brse_pkg; drives the memories in brse_store.
module brse_core #(
  parameter int WORDS    = 4096,
  parameter int SB_WORDS = 16,
  localparam int WAW     = $clog2(WORDS),
  localparam int BAW     = (WORDS / 8 > 1) ? $clog2(WORDS / 8) : 1,
  localparam int SAW     = $clog2(WORDS / SB_WORDS + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [16:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  brse_pkg::brse_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output brse_pkg::brse_out_t out_data_o,
  output brse_pkg::brse_we_t  we_o,
  output logic [WAW-1:0]     word_waddr_o,
  output logic [31:0]        word_wdata_o,
  output logic [WAW-1:0]     word_raddr_o,
  input  logic [31:0]        word_rdata_i,
  output logic [WAW-1:0]     lcnt_waddr_o,
  output logic [7:0]         lcnt_wdata_o,
  output logic [WAW-1:0]     lcnt_raddr_o,
  input  logic [7:0]         lcnt_rdata_i,
  output logic [BAW-1:0]     blk_waddr_o,
  output logic [17:0]        blk_wdata_o,
  output logic [BAW-1:0]     blk_raddr_o,
  input  logic [17:0]        blk_rdata_i,
  output logic [SAW-1:0]     sb_waddr_o,
  output logic [17:0]        sb_wdata_o,
  output logic [SAW-1:0]     sb_raddr_o,
  input  logic [17:0]        sb_rdata_i
);

  localparam int WQW     = (WAW + 1 > 12) ? WAW + 1 : 12;
  localparam int SCW     = (SB_WORDS > 1) ? $clog2(SB_WORDS) : 1;
  localparam int NSB_MAX = WORDS / SB_WORDS;
  localparam int SBB     = 32 * SB_WORDS;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DONE  = 4'd1;
  localparam logic [3:0] ST_BRD   = 4'd2;
  localparam logic [3:0] ST_BWR   = 4'd3;
  localparam logic [3:0] ST_RRD   = 4'd4;
  localparam logic [3:0] ST_RSUM  = 4'd5;
  localparam logic [3:0] ST_SRD   = 4'd6;
  localparam logic [3:0] ST_SCMP  = 4'd7;
  localparam logic [3:0] ST_WRD   = 4'd8;
  localparam logic [3:0] ST_WCHK  = 4'd9;
  localparam logic [3:0] ST_SSCAN = 4'd10;
  localparam logic [3:0] ST_PRD   = 4'd11;
  localparam logic [3:0] ST_PCHK  = 4'd12;
  localparam logic [3:0] ST_PSCAN = 4'd13;
  localparam logic [3:0] ST_TRD   = 4'd14;
  localparam logic [3:0] ST_TBIT  = 4'd15;

  logic [3:0]          state_q, state_d;
  logic [16:0]         blen_q, blen_d;
  logic [WQW-1:0]      w_q, w_d;
  logic [4:0]          off_q, off_d;
  logic [17:0]         k_q, k_d;
  logic [SAW-1:0]      j_q, j_d;
  logic [WQW-1:0]      ws_q, ws_d;
  logic [18:0]         joff_q, joff_d;
  logic [WQW-1:0]      midws_q, midws_d;
  logic [17:0]         sbmid_q, sbmid_d;
  logic [18:0]         rem_q, rem_d;
  logic [31:0]         scan_q, scan_d;
  logic [4:0]          b_q, b_d;
  logic [31:0]         mask_q, mask_d;
  logic [17:0]         total_q, total_d;
  logic [7:0]          local_q, local_d;
  logic [SCW-1:0]      sbc_q, sbc_d;
  logic [SAW-1:0]      sbi_q, sbi_d;
  brse_pkg::brse_out_t res_q, res_d;
  brse_pkg::brse_out_t out_q, out_d;
  logic                out_valid_q, out_valid_d;

  logic                accept;
  logic                load;
  logic [WAW-1:0]      last_w;
  logic [WQW-1:0]      last_q_w;
  logic                in_range;
  logic [5:0]          pc;
  logic [31:0]         pfull;
  logic                mid_hit;
  logic [WQW-1:0]      ws_sel;
  logic [17:0]         sb_sel;
  logic                first_in_blk;
  logic [31:0]         pv;
  logic [11:0]         in_w;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Last word covered by bit_length
  assign last_w   = (32'(blen_q[16:5]) < WORDS) ? WAW'(blen_q[16:5]) : WAW'(WORDS - 1);
  assign last_q_w = WQW'(last_w);
  assign in_range = 32'(w_q) < WORDS;
  assign in_w     = in_data_i.position[16:5];

  // Shared unit: one word popcount, selected by state
  always_comb begin
    if (state_q == ST_RSUM) begin
      pc = brse_pkg::popcnt32(word_rdata_i << (5'd31 - off_q));
    end else begin
      pc = brse_pkg::popcnt32(word_rdata_i);
    end
  end

  assign pfull        = {{(32 - WQW - 5){1'b0}}, w_q, b_q};
  assign mid_hit      = sb_rdata_i < k_q;
  assign ws_sel       = mid_hit ? ws_q : midws_q;
  assign sb_sel       = mid_hit ? sb_rdata_i : sbmid_q;
  assign first_in_blk = (w_q[2:0] == 3'd0);
  assign pv           = (in_range ? word_rdata_i : 32'd0) & mask_q;

  // Memory addressing
  assign word_waddr_o = WAW'(in_data_i.word_index);
  assign word_wdata_o = in_data_i.word_data;
  assign word_raddr_o = WAW'(w_q);
  assign lcnt_raddr_o = WAW'(w_q);
  assign lcnt_waddr_o = WAW'(w_q);
  assign lcnt_wdata_o = first_in_blk ? 8'd0 : local_q;
  assign blk_raddr_o  = BAW'(w_q >> 3);
  assign blk_waddr_o  = BAW'(w_q >> 3);
  assign blk_wdata_o  = total_q;
  assign sb_raddr_o   = j_q;
  assign sb_waddr_o   = (state_q == ST_BWR) ? sbi_q + SAW'(1) : '0;
  assign sb_wdata_o   = (state_q == ST_BWR) ? total_q + 18'(pc) : 18'd0;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    blen_d      = cfg_we_i ? cfg_data_i : blen_q;
    w_d         = w_q;
    off_d       = off_q;
    k_d         = k_q;
    j_d         = j_q;
    ws_d        = ws_q;
    joff_d      = joff_q;
    midws_d     = midws_q;
    sbmid_d     = sbmid_q;
    rem_d       = rem_q;
    scan_d      = scan_q;
    b_d         = b_q;
    mask_d      = mask_q;
    total_d     = total_q;
    local_d     = local_q;
    sbc_d       = sbc_q;
    sbi_d       = sbi_q;
    res_d       = res_q;
    out_d       = out_q;
    load        = 1'b0;
    we_o        = '0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d = '0;
          off_d = in_data_i.position[4:0];
          k_d   = in_data_i.target_count;
          w_d   = WQW'(in_w);
          case (in_data_i.mode)
            brse_pkg::MODE_WRITE: begin
              we_o.word = 32'(in_data_i.word_index) < WORDS;
              state_d   = ST_DONE;
            end
            brse_pkg::MODE_BUILD: begin
              we_o.sb = 1'b1;
              w_d     = '0;
              total_d = '0;
              local_d = '0;
              sbc_d   = '0;
              sbi_d   = '0;
              state_d = ST_BRD;
            end
            brse_pkg::MODE_RANK: begin
              if (in_data_i.position > blen_q || 32'(in_w) >= WORDS) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_RRD;
              end
            end
            brse_pkg::MODE_SELECT: begin
              j_d    = '0;
              ws_d   = '0;
              joff_d = '0;
              if (in_data_i.target_count == 18'd0) begin
                res_d.not_found = 1'b1;
                state_d         = ST_DONE;
              end else begin
                state_d = ST_SRD;
              end
            end
            brse_pkg::MODE_PREV: begin
              mask_d  = 32'hFFFF_FFFF >> (5'd31 - in_data_i.position[4:0]);
              state_d = ST_PRD;
            end
            brse_pkg::MODE_TEST: begin
              state_d = ST_TRD;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      // Build: one word read, then counts written
      ST_BRD: state_d = ST_BWR;
      ST_BWR: begin
        we_o.lcnt = 1'b1;
        we_o.blk  = first_in_blk;
        local_d   = (first_in_blk ? 8'd0 : local_q) + 8'(pc);
        total_d   = total_q + 18'(pc);
        if (sbc_q == SCW'(SB_WORDS - 1)) begin
          we_o.sb = 1'b1;
          sbi_d   = sbi_q + SAW'(1);
          sbc_d   = '0;
        end else begin
          sbc_d = sbc_q + SCW'(1);
        end
        if (w_q == last_q_w) begin
          state_d = ST_DONE;
        end else begin
          w_d     = w_q + WQW'(1);
          state_d = ST_BRD;
        end
      end

      // Rank: block total, local count and masked word popcount
      ST_RRD: state_d = ST_RSUM;
      ST_RSUM: begin
        res_d.answer = blk_rdata_i + 18'(lcnt_rdata_i) + 18'(pc);
        state_d      = ST_DONE;
      end

      // Select: walk superblock totals for the last one below k
      ST_SRD: state_d = ST_SCMP;
      ST_SCMP: begin
        midws_d = ws_sel;
        sbmid_d = sb_sel;
        if (joff_q + 19'(SBB) <= 19'(blen_q) && 32'(j_q) < NSB_MAX) begin
          j_d     = j_q + SAW'(1);
          ws_d    = ws_q + WQW'(SB_WORDS);
          joff_d  = joff_q + 19'(SBB);
          state_d = ST_SRD;
        end else begin
          rem_d = 19'(k_q) - 19'(sb_sel);
          if (ws_sel > last_q_w) begin
            res_d.not_found = 1'b1;
            state_d         = ST_DONE;
          end else begin
            w_d     = ws_sel;
            state_d = ST_WRD;
          end
        end
      end

      // Select: walk words until the remaining count falls in one
      ST_WRD: state_d = ST_WCHK;
      ST_WCHK: begin
        if (19'(pc) >= rem_q) begin
          scan_d  = word_rdata_i;
          b_d     = '0;
          state_d = ST_SSCAN;
        end else begin
          rem_d = rem_q - 19'(pc);
          if (w_q == last_q_w) begin
            res_d.not_found = 1'b1;
            state_d         = ST_DONE;
          end else begin
            w_d     = w_q + WQW'(1);
            state_d = ST_WRD;
          end
        end
      end

      // Select: one bit a cycle, upward
      ST_SSCAN: begin
        scan_d = scan_q >> 1;
        b_d    = b_q + 5'd1;
        if (scan_q[0]) begin
          rem_d = rem_q - 19'd1;
          if (rem_q == 19'd1) begin
            if (pfull > 32'(blen_q)) begin
              res_d.not_found = 1'b1;
            end else begin
              res_d.answer = 18'(pfull);
            end
            state_d = ST_DONE;
          end
        end
      end

      // Prev: walk words downward to the first nonzero one
      ST_PRD: state_d = ST_PCHK;
      ST_PCHK: begin
        if (pv != 32'd0) begin
          scan_d  = pv;
          b_d     = 5'd31;
          state_d = ST_PSCAN;
        end else if (w_q == '0) begin
          res_d.not_found = 1'b1;
          state_d         = ST_DONE;
        end else begin
          w_d     = w_q - WQW'(1);
          mask_d  = 32'hFFFF_FFFF;
          state_d = ST_PRD;
        end
      end

      // Prev: one bit a cycle, downward
      ST_PSCAN: begin
        if (scan_q[31]) begin
          res_d.answer = 18'(pfull);
          state_d      = ST_DONE;
        end else begin
          scan_d = scan_q << 1;
          b_d    = b_q - 5'd1;
        end
      end

      // Test bit
      ST_TRD: state_d = ST_TBIT;
      ST_TBIT: begin
        res_d.bit_value = in_range ? word_rdata_i[off_q] : 1'b0;
        state_d         = ST_DONE;
      end

      // Hand the beat to the output register
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          out_d   = res_q;
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = load || (out_valid_q && out_stall_i);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      blen_q      <= brse_pkg::LEN_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      blen_q      <= blen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    off_q   <= off_d;
    k_q     <= k_d;
    j_q     <= j_d;
    ws_q    <= ws_d;
    joff_q  <= joff_d;
    midws_q <= midws_d;
    sbmid_q <= sbmid_d;
    rem_q   <= rem_d;
    scan_q  <= scan_d;
    b_q     <= b_d;
    mask_q  <= mask_d;
    total_q <= total_d;
    local_q <= local_d;
    sbc_q   <= sbc_d;
    sbi_q   <= sbi_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> state_q == ST_DONE)
    else $error("result loaded outside the done state");

  a_build_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_BWR |-> w_q <= last_q_w)
    else $error("build walked past the last word");

  a_select_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WCHK |-> rem_q != 19'd0)
    else $error("select remainder reached zero between words");

  a_done_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_valid_q) |=> out_valid_q && state_q == ST_IDLE)
    else $error("finished result not moved to the output register");

endmodule

>>> src/bitvector_rank_select_engine_unit.sv
// Rank/select engine over a bit vector of 32-bit words: rank, select, prev and test bit.
// Write goes straight to the result; rank and test read, then compute; build reads and
// writes each word up to the last word; select walks superblock totals, then words, then
// scans bits; prev walks words downward, then scans bits. One item at a time, set by the
// shared popcount/scan unit. Reset clears the sequencer and output valid and sets
// bit_length to 131071; memories are not cleared. Depends on brse_pkg, brse_store, brse_core.
module bitvector_rank_select_engine_unit #(
  parameter int WORDS    = 4096,
  parameter int SB_WORDS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brse_pkg::brse_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output brse_pkg::brse_out_t out_data_o
);

  localparam int WAW = $clog2(WORDS);
  localparam int BAW = (WORDS / 8 > 1) ? $clog2(WORDS / 8) : 1;
  localparam int SAW = $clog2(WORDS / SB_WORDS + 1);

  brse_pkg::brse_we_t we;
  logic [WAW-1:0] word_waddr, word_raddr, lcnt_waddr, lcnt_raddr;
  logic [31:0]    word_wdata, word_rdata;
  logic [7:0]     lcnt_wdata, lcnt_rdata;
  logic [BAW-1:0] blk_waddr, blk_raddr;
  logic [17:0]    blk_wdata, blk_rdata;
  logic [SAW-1:0] sb_waddr, sb_raddr;
  logic [17:0]    sb_wdata, sb_rdata;

  // Sequencer and shared datapath
  brse_core #(.WORDS(WORDS), .SB_WORDS(SB_WORDS)) u_core (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o,
    .we_o(we),
    .word_waddr_o(word_waddr), .word_wdata_o(word_wdata),
    .word_raddr_o(word_raddr), .word_rdata_i(word_rdata),
    .lcnt_waddr_o(lcnt_waddr), .lcnt_wdata_o(lcnt_wdata),
    .lcnt_raddr_o(lcnt_raddr), .lcnt_rdata_i(lcnt_rdata),
    .blk_waddr_o(blk_waddr), .blk_wdata_o(blk_wdata),
    .blk_raddr_o(blk_raddr), .blk_rdata_i(blk_rdata),
    .sb_waddr_o(sb_waddr), .sb_wdata_o(sb_wdata),
    .sb_raddr_o(sb_raddr), .sb_rdata_i(sb_rdata)
  );

  // Word and index memories
  brse_store #(.WORDS(WORDS), .SB_WORDS(SB_WORDS)) u_store (
    .clk_i, .we_i(we),
    .word_waddr_i(word_waddr), .word_wdata_i(word_wdata),
    .word_raddr_i(word_raddr), .word_rdata_o(word_rdata),
    .lcnt_waddr_i(lcnt_waddr), .lcnt_wdata_i(lcnt_wdata),
    .lcnt_raddr_i(lcnt_raddr), .lcnt_rdata_o(lcnt_rdata),
    .blk_waddr_i(blk_waddr), .blk_wdata_i(blk_wdata),
    .blk_raddr_i(blk_raddr), .blk_rdata_o(blk_rdata),
    .sb_waddr_i(sb_waddr), .sb_wdata_i(sb_wdata),
    .sb_raddr_i(sb_raddr), .sb_rdata_o(sb_rdata)
  );

endmodule

>>> dv/tb_bitvector_rank_select_engine_unit.sv
// Testbench for bitvector_rank_select_engine_unit: fills the low part of the word store,
// builds the index, then checks rank, select, prev and bit tests against a cycle-free
// predictor over several bit_length settings and idle/stall mixes. Depends on brse_pkg and the RTL.
module tb_bitvector_rank_select_engine_unit;

  localparam int NWORDS = 4096;
  localparam int SBW    = 16;
  // Words written up front; every length used keeps reads inside them
  localparam int NUSED  = 128;
  localparam int unsigned LEN_FULL = 4000;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int unsigned CNT_MASK = 32'h3FFFF;

  // Predictor of the engine plus the queue of results still owed
  class rank_select_checker;
    logic [31:0] words [NWORDS];
    int unsigned blk_tot [NWORDS/8 + 1];
    int unsigned loc_cnt [NWORDS];
    int unsigned sb_tot [NWORDS/SBW + 2];
    int unsigned bit_len;
    int unsigned ones_total;
    int errors;
    brse_pkg::brse_out_t expected_answers [$];

    function new();
      bit_len = brse_pkg::LEN_RESET;
      ones_total = 0;
      errors = 0;
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function int unsigned last_word();
      int unsigned w;
      w = bit_len >> 5;
      return (w < NWORDS) ? w : NWORDS - 1;
    endfunction

    function int unsigned sb_count();
      int unsigned n;
      n = bit_len / (32 * SBW);
      return (n > NWORDS / SBW) ? NWORDS / SBW : n;
    endfunction

    function void rebuild();
      int unsigned last, total, loc, pc, nsb, acc;
      last = last_word();
      total = 0;
      loc = 0;
      for (int unsigned i = 0; i <= last; i++) begin
        pc = $countones(words[i]);
        if (i % 8 == 0) begin
          blk_tot[i / 8] = total & CNT_MASK;
          loc = 0;
        end
        loc_cnt[i] = loc & 8'hFF;
        loc += pc;
        total += pc;
      end
      ones_total = total;
      nsb = sb_count();
      sb_tot[0] = 0;
      for (int unsigned j = 1; j <= nsb; j++) begin
        acc = sb_tot[j-1];
        for (int unsigned i = (j - 1) * SBW; i < j * SBW; i++)
          if (i <= last) acc += $countones(words[i]);
        sb_tot[j] = acc & CNT_MASK;
      end
    endfunction

    function int unsigned rank_of(int unsigned p);
      int unsigned w, s;
      logic [31:0] shifted;
      if (p > bit_len) return 0;
      w = p >> 5;
      shifted = words[w] << (31 - (p & 31));
      s = blk_tot[w / 8] + loc_cnt[w] + $countones(shifted);
      return s & CNT_MASK;
    endfunction

    // Returns 1 and the position when the k-th one exists within bit_len
    function bit select_of(int unsigned k, output int unsigned pos);
      int unsigned nsb, mid, rem, last, c;
      pos = 0;
      if (k == 0) return 0;
      nsb = sb_count();
      mid = 0;
      for (int unsigned j = 0; j <= nsb; j++)
        if (sb_tot[j] < k) mid = j;
      rem = k - sb_tot[mid];
      last = last_word();
      for (int unsigned w = mid * SBW; w <= last; w++) begin
        c = $countones(words[w]);
        if (c >= rem) begin
          for (int unsigned b = 0; b < 32; b++) begin
            if (words[w][b]) begin
              rem--;
              if (rem == 0) begin
                if (w * 32 + b > bit_len) return 0;
                pos = w * 32 + b;
                return 1;
              end
            end
          end
          return 0;
        end
        rem -= c;
      end
      return 0;
    endfunction

    function bit prev_of(int unsigned p, output int unsigned pos);
      int unsigned w, b;
      logic [31:0] v;
      pos = 0;
      w = p >> 5;
      v = words[w] & (32'hFFFF_FFFF >> (31 - (p & 31)));
      forever begin
        if (v != 0) begin
          b = 31;
          while (!v[b]) b--;
          pos = w * 32 + b;
          return 1;
        end
        if (w == 0) return 0;
        w--;
        v = words[w];
      end
    endfunction

    function void note_item(brse_pkg::brse_in_t it);
      brse_pkg::brse_out_t r;
      int unsigned p;
      r = '0;
      case (it.mode)
        brse_pkg::MODE_WRITE: words[it.word_index] = it.word_data;
        brse_pkg::MODE_BUILD: rebuild();
        brse_pkg::MODE_RANK:  r.answer = 18'(rank_of(it.position));
        brse_pkg::MODE_SELECT: begin
          if (select_of(it.target_count, p)) r.answer = 18'(p);
          else r.not_found = 1'b1;
        end
        brse_pkg::MODE_PREV: begin
          if (prev_of(it.position, p)) r.answer = 18'(p);
          else r.not_found = 1'b1;
        end
        brse_pkg::MODE_TEST: r.bit_value = words[it.position >> 5][it.position[4:0]];
        default: ;
      endcase
      expected_answers.push_back(r);
    endfunction

    task check_answer(brse_pkg::brse_out_t got);
      brse_pkg::brse_out_t exp_r;
      if (expected_answers.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      exp_r = expected_answers.pop_front();
      if (got.answer !== exp_r.answer)
        report($sformatf("answer %0d, predicted %0d", got.answer, exp_r.answer));
      if (got.bit_value !== exp_r.bit_value)
        report($sformatf("bit_value %b, predicted %b", got.bit_value, exp_r.bit_value));
      if (got.not_found !== exp_r.not_found)
        report($sformatf("not_found %b, predicted %b", got.not_found, exp_r.not_found));
    endtask
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_we_i = 1'b0;
  logic [16:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  brse_pkg::brse_in_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  brse_pkg::brse_out_t out_data_o;

  rank_select_checker scb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;

  bitvector_rank_select_engine_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = 300;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) scb.check_answer(out_data_o);
  end

  // Drive one beat; entered and left at a falling edge
  task automatic send_item(brse_pkg::brse_in_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    scb.note_item(it);
    @(negedge clk_i);
  endtask

  task automatic send_mode(logic [2:0] m, int unsigned pos, int unsigned k);
    brse_pkg::brse_in_t it;
    it = '0;
    it.mode = m;
    it.position = 17'(pos);
    it.target_count = 18'(k);
    send_item(it);
  endtask

  task automatic send_write(int unsigned idx, logic [31:0] data);
    brse_pkg::brse_in_t it;
    it = '0;
    it.mode = brse_pkg::MODE_WRITE;
    it.word_index = 12'(idx);
    it.word_data = data;
    send_item(it);
  endtask

  // Let every owed result drain, then return at a falling edge
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (scb.expected_answers.size() != 0);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_length(int unsigned len);
    cfg_we_i <= 1'b1;
    cfg_data_i <= 17'(len);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    scb.bit_len = len;
  endtask

  function automatic logic [31:0] word_pattern();
    case ($urandom_range(5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic brse_pkg::brse_in_t random_item();
    brse_pkg::brse_in_t it;
    int unsigned r, lim;
    it = '0;
    it.word_index = 12'($urandom);
    it.word_data = word_pattern();
    it.target_count = 18'($urandom);
    // Positions reach a little past the length but stay in the written words
    lim = scb.bit_len + 40;
    if (lim > NUSED * 32 - 1) lim = NUSED * 32 - 1;
    it.position = 17'($urandom_range(lim));
    if ($urandom_range(99) < 85) it.target_count = 18'($urandom_range(scb.ones_total + 2));
    if ($urandom_range(99) < 70) it.word_index = 12'($urandom_range(scb.last_word()));
    r = $urandom_range(99);
    if (r < 20) it.mode = brse_pkg::MODE_WRITE;
    else if (r < 23) it.mode = brse_pkg::MODE_BUILD;
    else if (r < 48) it.mode = brse_pkg::MODE_RANK;
    else if (r < 70) it.mode = brse_pkg::MODE_SELECT;
    else if (r < 85) it.mode = brse_pkg::MODE_PREV;
    else if (r < 95) it.mode = brse_pkg::MODE_TEST;
    else it.mode = ($urandom_range(1) != 0) ? MODE_SPARE7 : MODE_SPARE6;
    return it;
  endfunction

  initial begin
    int unsigned lengths [7];
    int unsigned t;
    lengths = '{4000, 1, 31, 32, 777, 2500, 4000};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Every word that is read gets written first
    write_length(LEN_FULL);
    for (int i = 0; i < NUSED; i++) begin
      if (i == 0) send_write(i, 32'h0);
      else if (i == 1) send_write(i, 32'h8000_0000);
      else if (i == 2) send_write(i, 32'hFFFF_FFFF);
      else send_write(i, word_pattern());
    end
    send_mode(brse_pkg::MODE_BUILD, 0, 0);

    // Directed: extremes, empty prev, select bounds, stale index, spare modes
    t = scb.ones_total;
    send_mode(brse_pkg::MODE_RANK, 0, 0);
    send_mode(brse_pkg::MODE_RANK, LEN_FULL, 0);
    send_mode(brse_pkg::MODE_RANK, 95, 0);
    send_mode(brse_pkg::MODE_RANK, 131071, 0);
    send_mode(brse_pkg::MODE_SELECT, 0, 0);
    send_mode(brse_pkg::MODE_SELECT, 0, 1);
    send_mode(brse_pkg::MODE_SELECT, 0, t);
    send_mode(brse_pkg::MODE_SELECT, 0, t + 1);
    send_mode(brse_pkg::MODE_SELECT, 0, 18'h3FFFF);
    send_mode(brse_pkg::MODE_PREV, 5, 0);
    send_mode(brse_pkg::MODE_PREV, 40, 0);
    send_mode(brse_pkg::MODE_PREV, 63, 0);
    send_mode(brse_pkg::MODE_PREV, LEN_FULL, 0);
    send_mode(brse_pkg::MODE_TEST, 0, 0);
    send_mode(brse_pkg::MODE_TEST, 63, 0);
    send_mode(brse_pkg::MODE_TEST, NUSED * 32 - 1, 0);
    send_mode(MODE_SPARE6, 131071, 18'h3FFFF);
    send_mode(MODE_SPARE7, 0, 0);
    send_write(3, 32'hFFFF_0000);
    send_mode(brse_pkg::MODE_RANK, 127, 0);
    send_mode(brse_pkg::MODE_SELECT, 0, 40);
    send_write(LEN_FULL >> 5, 32'hFF00_0000);
    send_mode(brse_pkg::MODE_BUILD, 0, 0);
    send_mode(brse_pkg::MODE_RANK, LEN_FULL, 0);
    send_mode(brse_pkg::MODE_SELECT, 0, scb.ones_total);

    // Random phases over several lengths and idle/stall mixes
    for (int ph = 0; ph < 7; ph++) begin
      wait_idle();
      idle_pct = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 3) ? 38 : 78) : 0;
      stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 3) ? 38 : 78) : 0;
      write_length(lengths[ph]);
      send_mode(brse_pkg::MODE_BUILD, 0, 0);
      if (ph == 4) begin
        idle_pct = 0;
        stall_pct = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < 34; n++) send_item(random_item());
    end
    wait_idle();

    if (scb.errors == 0)
      $display("bitvector_rank_select_engine_unit regression: pass");
    else
      $display("bitvector_rank_select_engine_unit regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #8000000;
    $display("bitvector_rank_select_engine_unit regression: fail");
    $finish;
  end

endmodule
